// ----- src/mskf_pkg.sv -----
`timescale 1ns / 1ps
// package for the motor state filter: payload types, codes, constants and fixed-point helpers
package mskf_pkg;

  // accumulator wide enough for four 32x64 products plus the added term
  localparam int ACC_W = 100;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< 23;

  localparam logic [1:0] CMD_PREDICT = 2'd0;
  localparam logic [1:0] CMD_UPDATE  = 2'd1;
  localparam logic [1:0] CMD_BOTH    = 2'd2;
  localparam logic [1:0] CMD_REINIT  = 2'd3;

  localparam logic [2:0] REG_VEL       = 3'd0;
  localparam logic [2:0] REG_LOAD_STEP = 3'd1;
  localparam logic [2:0] REG_CUR       = 3'd2;
  localparam logic [2:0] REG_DRIVE     = 3'd3;
  localparam logic [2:0] REG_NOISE_PV  = 3'd4;
  localparam logic [2:0] REG_NOISE_CL  = 3'd5;
  localparam logic [2:0] REG_MEAS      = 3'd6;

  localparam logic [63:0] VEL_RST       = 64'h0100_0000_0000_0000;
  localparam logic [63:0] LOAD_STEP_RST = 64'h0;
  localparam logic [63:0] CUR_RST       = 64'h0000_0000_0100_0000;
  localparam logic [31:0] DRIVE_RST     = 32'h0;
  localparam logic [63:0] NOISE_RST     = 64'h0000_4189_0000_4189;
  localparam logic [30:0] MEAS_RST      = 31'd168;

  localparam logic signed [32:0] COEF_ONE = 33'sh0_0100_0000;

  // state memory map: covariance upper triangle at 0..9, estimates at 10..13
  localparam logic [3:0] EST_BASE  = 4'd10;
  localparam logic [3:0] LAST_ADDR = 4'd13;

  // gain division: 64-bit magnitude shifted up by 24
  localparam int NUM_W = 88;
  localparam logic [6:0] DIV_LAST = 7'd87;

  // phases of one multiply-accumulate term
  localparam logic [2:0] PH_RD  = 3'd0;
  localparam logic [2:0] PH_LO  = 3'd1;
  localparam logic [2:0] PH_HI  = 3'd2;
  localparam logic [2:0] PH_ACC = 3'd3;
  localparam logic [2:0] PH_WR  = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] drive_voltage;
    logic signed [31:0] encoder_angle;
  } mskf_in_t;

  typedef struct packed {
    logic signed [31:0] angle_est;
    logic signed [31:0] speed_est;
    logic signed [31:0] current_est;
    logic signed [31:0] load_est;
    logic signed [31:0] gain_angle;
    logic signed [31:0] gain_speed;
    logic signed [31:0] gain_current;
    logic signed [31:0] gain_load;
    logic               saturated;
  } mskf_out_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DRV, ST_NX, ST_FP, ST_PP, ST_CPX, ST_ULD, ST_UPREP,
    ST_UDIV, ST_UGAIN, ST_UX, ST_UP, ST_REINIT, ST_ORD
  } mskf_state_t;

  function automatic logic [3:0] tri_idx(input logic [1:0] r, input logic [1:0] c);
    logic [3:0] a;
    case ({r, c})
      4'b0000: a = 4'd0;
      4'b0001, 4'b0100: a = 4'd1;
      4'b0010, 4'b1000: a = 4'd2;
      4'b0011, 4'b1100: a = 4'd3;
      4'b0101: a = 4'd4;
      4'b0110, 4'b1001: a = 4'd5;
      4'b0111, 4'b1101: a = 4'd6;
      4'b1010: a = 4'd7;
      4'b1011, 4'b1110: a = 4'd8;
      default: a = 4'd9;
    endcase
    return a;
  endfunction

  function automatic logic is_diag(input logic [3:0] a);
    return (a == 4'd0) || (a == 4'd4) || (a == 4'd7) || (a == 4'd9);
  endfunction

  // round half up by 24 bits, then clip to 64 bits
  function automatic logic signed [63:0] red64(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic [ACC_W-64:0] top;
    t = a + RND_HALF;
    t = t >>> 24;
    top = t[ACC_W-1:63];
    if ((&top) || !(|top)) return t[63:0];
    return t[ACC_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic signed [63:0] sat66(input logic signed [65:0] d);
    if ((&d[65:63]) || !(|d[65:63])) return d[63:0];
    return d[65] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
  endfunction

endpackage

// ----- src/motor_state_kalman_filter.sv -----
`timescale 1ns / 1ps
// motor state filter: four-state predict and angle update over a shared multiplier
//
//  channel | signals                                  | beat
//  in      | in_valid, in_ready, in_data              | cmd, drive_voltage, encoder_angle
//  out     | out_valid, out_ready, out_data           | estimates, gains, saturated
//  cfg     | cfg_psel/penable/pwrite/paddr/pwdata/... | one register write or read
//
// one item at a time: predict runs each term through one 33x33 multiplier as a low and
// a high half product, update adds a four-lane gain division, reinit rewrites the state
// memory, and every command ends by reading the estimates out
// after reset a clearing pass writes the identity covariance, in_ready stays low meanwhile
// a stalled result beat holds the next item only when it is ready to be shown
module motor_state_kalman_filter
  import mskf_pkg::*;
#(
  parameter int INTERNAL_FRAC_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  mskf_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output mskf_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DRV_SH = INTERNAL_FRAC_BITS - 16;
  localparam int R_SH   = INTERNAL_FRAC_BITS - 24;
  localparam int OUT_SH = INTERNAL_FRAC_BITS - 16;
  localparam logic [63:0] ONE_P = 64'(1) << INTERNAL_FRAC_BITS;
  localparam logic signed [64:0] O_HALF = 65'sd1 <<< (OUT_SH - 1);

  // configuration
  logic [63:0] vel_r, lsc_r, cur_r, npv_r, ncl_r;
  logic [31:0] drv_r;
  logic [30:0] meas_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // control
  mskf_state_t state_r, state_nxt;
  logic [2:0]  ph_r;
  logic [1:0]  i_r, j_r, k_r;
  logic [6:0]  cnt_r;
  logic        out_valid_r;
  mskf_out_t   out_data_r;

  // payload
  logic [1:0]               cmd_r;
  logic signed [31:0]       u_r, z_r;
  logic signed [63:0]       du_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [65:0]       prod_r;
  logic signed [63:0]       row0_r [4];
  logic signed [63:0]       est0_r, y_r;
  logic [63:0]              s_r;
  logic [62:0]              rem_r [4];
  logic [32:0]              q_r [4];
  logic [3:0]               big_r;
  logic [NUM_W-1:0]         num_r [4];
  logic signed [31:0]       gain_r [4];
  logic                     clip_r;

  // memories
  logic [63:0] st_mem [16];
  logic [63:0] wk_mem [20];
  logic [63:0] st_rd_r, wk_rd_r;
  logic [3:0]  st_ra, st_wa;
  logic [4:0]  wk_ra, wk_wa;
  logic        st_we, wk_we;
  logic [63:0] st_wd, wk_wd;

  // datapath signals
  logic               elem, upd, elem_last, hold_out;
  logic [1:0]         i_adv, j_adv, frow;
  logic signed [32:0] fco, coef, mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]        opnd;
  logic signed [ACC_W-1:0] init_val, upd_init, prod_ext, du_ext, st_ext;
  logic [ACC_W-1:0]   q_ext;
  logic [31:0]        qsel;
  logic signed [63:0] acc_red;
  logic [2:0]         ld_slot;
  logic signed [64:0] s_full;
  logic signed [63:0] s_sat;
  logic signed [65:0] zsh, ydiff;
  logic signed [64:0] o_t;
  logic               oclip;
  logic [31:0]        oval;
  logic [63:0]        trial [4];
  logic [62:0]        rem_nxt [4];
  logic [32:0]        q_nxt [4];
  logic [3:0]         big_nxt;
  logic [32:0]        limit [4];
  logic [31:0]        gq [4];
  logic signed [31:0] gain_nxt [4];
  logic [3:0]         gclip;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_VEL:       cfg_prdata = vel_r;
      REG_LOAD_STEP: cfg_prdata = lsc_r;
      REG_CUR:       cfg_prdata = cur_r;
      REG_DRIVE:     cfg_prdata = {32'b0, drv_r};
      REG_NOISE_PV:  cfg_prdata = npv_r;
      REG_NOISE_CL:  cfg_prdata = ncl_r;
      REG_MEAS:      cfg_prdata = {33'b0, meas_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r  <= VEL_RST;
      lsc_r  <= LOAD_STEP_RST;
      cur_r  <= CUR_RST;
      drv_r  <= DRIVE_RST;
      npv_r  <= NOISE_RST;
      ncl_r  <= NOISE_RST;
      meas_r <= MEAS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VEL:       vel_r  <= cfg_pwdata;
        REG_LOAD_STEP: lsc_r  <= cfg_pwdata;
        REG_CUR:       cur_r  <= cfg_pwdata;
        REG_DRIVE:     drv_r  <= cfg_pwdata[31:0];
        REG_NOISE_PV:  npv_r  <= cfg_pwdata;
        REG_NOISE_CL:  ncl_r  <= cfg_pwdata;
        REG_MEAS:      meas_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  // element sequencing
  assign elem = (state_r == ST_NX) || (state_r == ST_FP) || (state_r == ST_PP) ||
                (state_r == ST_UX) || (state_r == ST_UP);
  assign upd  = (state_r == ST_UX) || (state_r == ST_UP);
  assign hold_out = (i_r == 2'd0) && out_valid_r && !out_ready;

  always_comb begin
    elem_last = 1'b0;
    i_adv = i_r;
    j_adv = j_r;
    case (state_r)
      ST_NX, ST_UX: begin
        elem_last = (i_r == 2'd3);
        i_adv = i_r + 2'd1;
      end
      ST_FP: begin
        elem_last = (i_r == 2'd3) && (j_r == 2'd3);
        if (j_r == 2'd3) begin
          i_adv = i_r + 2'd1;
          j_adv = 2'd0;
        end else begin
          j_adv = j_r + 2'd1;
        end
      end
      ST_PP, ST_UP: begin
        elem_last = (i_r == 2'd3) && (j_r == 2'd3);
        if (j_r == 2'd3) begin
          i_adv = i_r + 2'd1;
          j_adv = i_r + 2'd1;
        end else begin
          j_adv = j_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:    if (cnt_r[3:0] == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.cmd)
            CMD_PREDICT, CMD_BOTH: state_nxt = ST_DRV;
            CMD_UPDATE:            state_nxt = ST_ULD;
            default:               state_nxt = ST_REINIT;
          endcase
        end
      end
      ST_DRV:    if (ph_r == PH_LO) state_nxt = ST_NX;
      ST_NX:     if (ph_r == PH_WR && elem_last) state_nxt = ST_FP;
      ST_FP:     if (ph_r == PH_WR && elem_last) state_nxt = ST_PP;
      ST_PP:     if (ph_r == PH_WR && elem_last) state_nxt = ST_CPX;
      ST_CPX: begin
        if (ph_r == PH_LO && i_r == 2'd3) state_nxt = (cmd_r == CMD_BOTH) ? ST_ULD : ST_ORD;
      end
      ST_ULD:    if (cnt_r == 7'd5) state_nxt = ST_UPREP;
      ST_UPREP:  state_nxt = ST_UDIV;
      ST_UDIV:   if (cnt_r == DIV_LAST) state_nxt = ST_UGAIN;
      ST_UGAIN:  state_nxt = ST_UX;
      ST_UX:     if (ph_r == PH_WR && elem_last) state_nxt = ST_UP;
      ST_UP:     if (ph_r == PH_WR && elem_last) state_nxt = ST_ORD;
      ST_REINIT: if (cnt_r[3:0] == LAST_ADDR) state_nxt = ST_ORD;
      ST_ORD:    if (ph_r == PH_LO && i_r == 2'd3) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory addressing and writes
  always_comb begin
    st_ra = '0;
    wk_ra = '0;
    st_we = 1'b0;
    st_wa = '0;
    st_wd = '0;
    wk_we = 1'b0;
    wk_wa = '0;
    wk_wd = '0;
    unique case (state_r)
      ST_CLR, ST_REINIT: begin
        st_we = 1'b1;
        st_wa = cnt_r[3:0];
        st_wd = is_diag(cnt_r[3:0]) ? ONE_P : 64'b0;
      end
      ST_NX: begin
        st_ra = EST_BASE + {2'b00, k_r};
        wk_we = (ph_r == PH_WR);
        wk_wa = {3'b100, i_r};
        wk_wd = acc_red;
      end
      ST_FP: begin
        st_ra = tri_idx(k_r, j_r);
        wk_we = (ph_r == PH_WR);
        wk_wa = {1'b0, i_r, j_r};
        wk_wd = acc_red;
      end
      ST_PP: begin
        wk_ra = {1'b0, i_r, k_r};
        st_we = (ph_r == PH_WR);
        st_wa = tri_idx(i_r, j_r);
        st_wd = acc_red;
      end
      ST_CPX: begin
        wk_ra = {3'b100, i_r};
        st_we = (ph_r == PH_LO);
        st_wa = EST_BASE + {2'b00, i_r};
        st_wd = wk_rd_r;
      end
      ST_ULD: st_ra = cnt_r[2] ? EST_BASE : cnt_r[3:0];
      ST_UX: begin
        st_ra = EST_BASE + {2'b00, i_r};
        st_we = (ph_r == PH_WR);
        st_wa = st_ra;
        st_wd = acc_red;
      end
      ST_UP: begin
        st_ra = tri_idx(i_r, j_r);
        st_we = (ph_r == PH_WR);
        st_wa = st_ra;
        st_wd = acc_red;
      end
      ST_ORD: st_ra = EST_BASE + {2'b00, i_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_rd_r <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (wk_we) wk_mem[wk_wa] <= wk_wd;
    wk_rd_r <= wk_mem[wk_ra];
  end

  // multiplier operands
  assign frow = (state_r == ST_PP) ? j_r : i_r;

  always_comb begin
    case ({frow, k_r})
      4'b0000: fco = COEF_ONE;
      4'b0001: fco = {lsc_r[31], lsc_r[31:0]};
      4'b0101: fco = {vel_r[63], vel_r[63:32]};
      4'b0110: fco = {vel_r[31], vel_r[31:0]};
      4'b0111: fco = {lsc_r[63], lsc_r[63:32]};
      4'b1001: fco = {cur_r[63], cur_r[63:32]};
      4'b1010: fco = {cur_r[31], cur_r[31:0]};
      4'b1111: fco = COEF_ONE;
      default: fco = '0;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_UX:   coef = {gain_r[i_r][31], gain_r[i_r]};
      ST_UP:   coef = -{gain_r[i_r][31], gain_r[i_r]};
      default: coef = fco;
    endcase
    case (state_r)
      ST_PP:   opnd = wk_rd_r;
      ST_UX:   opnd = y_r;
      ST_UP:   opnd = row0_r[j_r];
      default: opnd = st_rd_r;
    endcase
    if (state_r == ST_DRV) begin
      mul_a = {drv_r[31], drv_r};
      mul_b = {u_r[31], u_r};
    end else begin
      mul_a = coef;
      mul_b = (ph_r == PH_HI) ? {opnd[63], opnd[63:32]} : {1'b0, opnd[31:0]};
    end
  end

  assign mul_p = mul_a * mul_b;

  // starting terms of an accumulation
  always_comb begin
    case (i_r)
      2'd0:    qsel = npv_r[63:32];
      2'd1:    qsel = npv_r[31:0];
      2'd2:    qsel = ncl_r[63:32];
      default: qsel = ncl_r[31:0];
    endcase
    du_ext   = {{(ACC_W-64){du_r[63]}}, du_r};
    q_ext    = {{(ACC_W-32){1'b0}}, qsel};
    st_ext   = {{(ACC_W-64){st_rd_r[63]}}, st_rd_r};
    prod_ext = {{(ACC_W-66){prod_r[65]}}, prod_r};
    upd_init = st_ext <<< 24;
    init_val = '0;
    if (state_r == ST_NX && i_r == 2'd2) init_val = du_ext <<< DRV_SH;
    if (state_r == ST_PP && i_r == j_r) init_val = q_ext << INTERNAL_FRAC_BITS;
  end

  assign acc_red = red64(acc_r);
  assign ld_slot = cnt_r[2:0] - 3'd1;

  // innovation variance and innovation
  always_comb begin
    s_full = {row0_r[0][63], row0_r[0]} + (65'(meas_r) <<< R_SH);
    if (s_full[64] != s_full[63]) s_sat = s_full[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    else s_sat = s_full[63:0];
    if (s_sat < 64'sd1) s_sat = 64'sd1;
    zsh   = {{34{z_r[31]}}, z_r} <<< DRV_SH;
    ydiff = zsh - {{2{est0_r[63]}}, est0_r};
  end

  // gain division lanes, one quotient bit each per cycle
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trial[l] = {rem_r[l], num_r[l][NUM_W-1]};
      if (trial[l] >= s_r) rem_nxt[l] = 63'(trial[l] - s_r);
      else rem_nxt[l] = trial[l][62:0];
      q_nxt[l]   = big_r[l] ? q_r[l] : {q_r[l][31:0], (trial[l] >= s_r)};
      big_nxt[l] = big_r[l] | q_nxt[l][32];
      limit[l]   = row0_r[l][63] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      gclip[l]   = big_r[l] || (q_r[l] > limit[l]);
      gq[l]      = gclip[l] ? limit[l][31:0] : q_r[l][31:0];
      gain_nxt[l] = row0_r[l][63] ? -gq[l] : gq[l];
    end
  end

  // estimate to Q16.16 output
  always_comb begin
    o_t   = {st_rd_r[63], st_rd_r} + O_HALF;
    o_t   = o_t >>> OUT_SH;
    oclip = !((&o_t[64:31]) || !(|o_t[64:31]));
    if (oclip) oval = o_t[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else oval = o_t[31:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ph_r        <= PH_RD;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < 4; l++) gain_r[l] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ORD && ph_r == PH_LO && i_r == 2'd3) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_UGAIN) begin
        for (int l = 0; l < 4; l++) gain_r[l] <= gain_nxt[l];
      end
      if (state_nxt != state_r) begin
        ph_r  <= PH_RD;
        i_r   <= '0;
        j_r   <= '0;
        k_r   <= '0;
        cnt_r <= '0;
      end else if (elem) begin
        case (ph_r)
          PH_RD: ph_r <= PH_LO;
          PH_LO: ph_r <= PH_HI;
          PH_HI: ph_r <= PH_ACC;
          PH_ACC: begin
            if (!upd && k_r != 2'd3) begin
              k_r  <= k_r + 2'd1;
              ph_r <= PH_RD;
            end else begin
              ph_r <= PH_WR;
            end
          end
          default: begin
            ph_r <= PH_RD;
            k_r  <= '0;
            i_r  <= i_adv;
            j_r  <= j_adv;
          end
        endcase
      end else begin
        case (state_r)
          ST_CLR, ST_REINIT, ST_ULD, ST_UDIV: cnt_r <= cnt_r + 7'd1;
          ST_DRV: ph_r <= PH_LO;
          ST_CPX, ST_ORD: begin
            if (ph_r == PH_RD) begin
              if (!(state_r == ST_ORD && hold_out)) ph_r <= PH_LO;
            end else begin
              ph_r <= PH_RD;
              i_r  <= i_r + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r  <= in_data.cmd;
          u_r    <= in_data.drive_voltage;
          z_r    <= in_data.encoder_angle;
          clip_r <= 1'b0;
        end
      end
      ST_DRV: begin
        if (ph_r == PH_RD) prod_r <= mul_p;
        else du_r <= prod_r[63:0];
      end
      ST_NX, ST_FP, ST_PP, ST_UX, ST_UP: begin
        case (ph_r)
          PH_RD: if (k_r == 2'd0) acc_r <= init_val;
          PH_LO: begin
            if (upd) acc_r <= upd_init;
            prod_r <= mul_p;
          end
          PH_HI: begin
            acc_r  <= acc_r + prod_ext;
            prod_r <= mul_p;
          end
          PH_ACC: acc_r <= acc_r + (prod_ext <<< 32);
          default: ;
        endcase
      end
      ST_ULD: begin
        if (cnt_r == 7'd5) est0_r <= st_rd_r;
        else if (cnt_r != 7'd0) row0_r[ld_slot[1:0]] <= st_rd_r;
      end
      ST_UPREP: begin
        s_r <= s_sat;
        y_r <= sat66(ydiff);
        for (int l = 0; l < 4; l++) begin
          num_r[l] <= {(row0_r[l][63] ? -row0_r[l] : row0_r[l]), 24'b0};
          rem_r[l] <= '0;
          q_r[l]   <= '0;
        end
        big_r <= '0;
      end
      ST_UDIV: begin
        for (int l = 0; l < 4; l++) begin
          num_r[l] <= num_r[l] << 1;
          rem_r[l] <= rem_nxt[l];
          q_r[l]   <= q_nxt[l];
        end
        big_r <= big_nxt;
      end
      ST_UGAIN: clip_r <= clip_r | (|gclip);
      ST_ORD: begin
        if (ph_r == PH_LO) begin
          clip_r <= clip_r | oclip;
          case (i_r)
            2'd0: out_data_r.angle_est   <= oval;
            2'd1: out_data_r.speed_est   <= oval;
            2'd2: out_data_r.current_est <= oval;
            default: begin
              out_data_r.load_est     <= oval;
              out_data_r.gain_angle   <= gain_r[0];
              out_data_r.gain_speed   <= gain_r[1];
              out_data_r.gain_current <= gain_r[2];
              out_data_r.gain_load    <= gain_r[3];
              out_data_r.saturated    <= clip_r | oclip;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// testbench for the motor state filter: random and directed commands, checked against a local predictor
module tb;
  import mskf_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mskf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mskf_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [5:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  motor_state_kalman_filter u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of registers and filter state
  logic [63:0] vel_r, lstep_r, cur_r, npv_r, ncl_r;
  logic [31:0] drv_r;
  logic [30:0] meas_r;
  logic signed [63:0] est[4];
  logic signed [63:0] cv[10];
  logic signed [31:0] kgain[4];
  bit step_clip;
  int tri_map[4][4] = '{'{0, 1, 2, 3}, '{1, 4, 5, 6}, '{2, 5, 7, 8}, '{3, 6, 8, 9}};

  mskf_in_t pending_cmds[$];
  mskf_out_t expected_est[$];
  int send_idle = 25, recv_idle = 46;
  bit hold_in = 1'b0;
  int errors = 0, beats_in = 0, beats_out = 0, n_upd = 0, n_clip = 0;

  function automatic logic signed [63:0] sat64(logic signed [127:0] a);
    if ((&a[127:63]) || !(|a[127:63])) return a[63:0];
    return a[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic signed [63:0] round_down(logic signed [127:0] a, int s);
    return sat64((a + (128'sd1 <<< (s - 1))) >>> s);
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < 10; i++) cv[i] = 0;
    foreach (tri_map[i]) cv[tri_map[i][i]] = 64'sd1 <<< 40;
    for (int i = 0; i < 4; i++) est[i] = 0;
  endfunction

  function automatic void run_predict(logic signed [31:0] volts);
    logic signed [31:0] f[4][4];
    logic signed [63:0] qn[4], fp[4][4], nx[4], bu;
    logic signed [127:0] acc;
    f = '{default: '0};
    f[0][0] = 32'sh0100_0000;
    f[0][1] = lstep_r[31:0];
    f[1][1] = vel_r[63:32];
    f[1][2] = vel_r[31:0];
    f[1][3] = lstep_r[63:32];
    f[2][1] = cur_r[63:32];
    f[2][2] = cur_r[31:0];
    f[3][3] = 32'sh0100_0000;
    qn[0] = {32'b0, npv_r[63:32]};
    qn[1] = {32'b0, npv_r[31:0]};
    qn[2] = {32'b0, ncl_r[63:32]};
    qn[3] = {32'b0, ncl_r[31:0]};
    bu = $signed(drv_r) * volts;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc = acc + f[i][k] * est[k];
      if (i == 2) acc = acc + bu * (128'sd1 <<< 24);
      nx[i] = round_down(acc, 24);
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc = acc + f[i][k] * cv[tri_map[k][j]];
        fp[i][j] = round_down(acc, 24);
      end
    for (int i = 0; i < 4; i++)
      for (int j = i; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc = acc + fp[i][k] * f[j][k];
        if (i == j) acc = acc + qn[i] * (128'sd1 <<< 40);
        cv[tri_map[i][j]] = round_down(acc, 24);
      end
    est = nx;
  endfunction

  function automatic void run_update(logic signed [31:0] z);
    logic signed [63:0] old[10], r, s, y, p;
    logic signed [127:0] pw;
    logic [127:0] num, quo, lim;
    old = cv;
    r = {33'b0, meas_r} <<< 16;
    s = sat64(128'(old[0]) + r);
    if (s < 1) s = 1;  // innovation floor
    for (int i = 0; i < 4; i++) begin
      p = old[tri_map[i][0]];
      pw = p;
      num = (pw < 0 ? -pw : pw) << 24;
      quo = num / {64'b0, s};
      lim = p < 0 ? 128'h8000_0000 : 128'h7fff_ffff;
      if (quo > lim) begin
        quo = lim;
        step_clip = 1'b1;
      end
      kgain[i] = p < 0 ? -quo[31:0] : quo[31:0];
    end
    y = sat64(z * (128'sd1 <<< 24) - est[0]);
    for (int i = 0; i < 4; i++)
      est[i] = round_down(est[i] * (128'sd1 <<< 24) + kgain[i] * y, 24);
    for (int i = 0; i < 4; i++)
      for (int j = i; j < 4; j++)
        cv[tri_map[i][j]] = round_down(old[tri_map[i][j]] * (128'sd1 <<< 24)
                                       - kgain[i] * old[tri_map[0][j]], 24);
  endfunction

  function automatic mskf_out_t filter_step(mskf_in_t it);
    mskf_out_t o;
    logic signed [63:0] v;
    logic signed [31:0] e32[4];
    step_clip = 1'b0;
    if (it.cmd == CMD_PREDICT || it.cmd == CMD_BOTH) run_predict(it.drive_voltage);
    if (it.cmd == CMD_UPDATE || it.cmd == CMD_BOTH) run_update(it.encoder_angle);
    if (it.cmd == CMD_REINIT) clear_state();
    for (int i = 0; i < 4; i++) begin
      v = round_down(est[i], 24);
      if (v > 64'sh7fff_ffff) begin
        v = 64'sh7fff_ffff;
        step_clip = 1'b1;
      end else if (v < -64'sh8000_0000) begin
        v = -64'sh8000_0000;
        step_clip = 1'b1;
      end
      e32[i] = v[31:0];
    end
    o.angle_est = e32[0];
    o.speed_est = e32[1];
    o.current_est = e32[2];
    o.load_est = e32[3];
    o.gain_angle = kgain[0];
    o.gain_speed = kgain[1];
    o.gain_current = kgain[2];
    o.gain_load = kgain[3];
    o.saturated = step_clip;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on beat %0d: %s got %h expected %h", beats_out, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_est.push_back(filter_step(in_data));
        if (in_data.cmd == CMD_UPDATE || in_data.cmd == CMD_BOTH) n_upd++;
        beats_in++;
      end
      if (!hold_in && pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle;
      if (out_valid && out_ready) begin
        if (expected_est.size() == 0) begin
          $display("result beat %0d arrived with nothing outstanding", beats_out);
          errors++;
        end else begin
          mskf_out_t w;
          w = expected_est.pop_front();
          if (out_data.angle_est !== w.angle_est) report("angle_est", out_data.angle_est, w.angle_est);
          if (out_data.speed_est !== w.speed_est) report("speed_est", out_data.speed_est, w.speed_est);
          if (out_data.current_est !== w.current_est)
            report("current_est", out_data.current_est, w.current_est);
          if (out_data.load_est !== w.load_est) report("load_est", out_data.load_est, w.load_est);
          if (out_data.gain_angle !== w.gain_angle)
            report("gain_angle", out_data.gain_angle, w.gain_angle);
          if (out_data.gain_speed !== w.gain_speed)
            report("gain_speed", out_data.gain_speed, w.gain_speed);
          if (out_data.gain_current !== w.gain_current)
            report("gain_current", out_data.gain_current, w.gain_current);
          if (out_data.gain_load !== w.gain_load) report("gain_load", out_data.gain_load, w.gain_load);
          if (out_data.saturated !== w.saturated) report("saturated", out_data.saturated, w.saturated);
          if (w.saturated) n_clip++;
        end
        beats_out++;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_VEL: vel_r = val;
      REG_LOAD_STEP: lstep_r = val;
      REG_CUR: cur_r = val;
      REG_DRIVE: drv_r = val[31:0];
      REG_NOISE_PV: npv_r = val;
      REG_NOISE_CL: ncl_r = val;
      REG_MEAS: meas_r = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [63:0] v, logic [63:0] ls, logic [63:0] c, logic [31:0] d,
                           logic [63:0] pv, logic [63:0] cl, logic [30:0] m);
    reg_write(REG_VEL, v);
    reg_write(REG_LOAD_STEP, ls);
    reg_write(REG_CUR, c);
    reg_write(REG_DRIVE, {32'b0, d});
    reg_write(REG_NOISE_PV, pv);
    reg_write(REG_NOISE_CL, cl);
    reg_write(REG_MEAS, {33'b0, m});
  endtask

  // plausible motor: slight damping, small step, modest noise
  task automatic load_plausible();
    load_regs({32'h0100_0000 - $urandom_range(0, 1 << 20), 32'($urandom_range(0, 1 << 20))},
              {-32'($urandom_range(0, 1 << 18)), 32'($urandom_range(1, 1 << 16))},
              {-32'($urandom_range(0, 1 << 20)), 32'h0100_0000 - $urandom_range(0, 1 << 22)},
              32'($urandom_range(0, 1 << 21)) - 32'h0010_0000,
              {32'($urandom_range(0, 1 << 16)), 32'($urandom_range(0, 1 << 16))},
              {32'($urandom_range(0, 1 << 16)), 32'($urandom_range(0, 1 << 16))},
              31'($urandom_range(0, 1 << 20)));
  endtask

  function automatic mskf_in_t mk(logic [1:0] c, logic [31:0] v, logic [31:0] z);
    mskf_in_t it;
    it.cmd = c;
    it.drive_voltage = v;
    it.encoder_angle = z;
    return it;
  endfunction

  function automatic mskf_in_t rand_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return mk(2'($urandom), $urandom, $urandom);
    if (r < 24) return mk(CMD_REINIT, $urandom, $urandom);
    return mk(r < 70 ? CMD_BOTH : (r < 85 ? CMD_PREDICT : CMD_UPDATE),
              32'($urandom_range(0, 1 << 20)) - 32'h0008_0000,
              32'($urandom_range(0, 1 << 22)) - 32'h0020_0000);
  endfunction

  task automatic queue_random(int n);
    pending_cmds.push_back(mk(CMD_REINIT, 0, 0));
    repeat (n) pending_cmds.push_back(rand_cmd());
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_valid && expected_est.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    clear_state();
    for (int i = 0; i < 4; i++) kgain[i] = 0;
    vel_r = VEL_RST;
    lstep_r = LOAD_STEP_RST;
    cur_r = CUR_RST;
    drv_r = DRIVE_RST;
    npv_r = NOISE_RST;
    ncl_r = NOISE_RST;
    meas_r = MEAS_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes and every command
    pending_cmds.push_back(mk(CMD_PREDICT, 0, 0));
    pending_cmds.push_back(mk(CMD_PREDICT, 32'h7fff_ffff, 0));
    pending_cmds.push_back(mk(CMD_PREDICT, 32'h8000_0000, 0));
    pending_cmds.push_back(mk(CMD_UPDATE, 0, 32'h7fff_ffff));
    pending_cmds.push_back(mk(CMD_UPDATE, 0, 32'h8000_0000));
    pending_cmds.push_back(mk(CMD_UPDATE, 0, 32'h7fff_ffff));
    pending_cmds.push_back(mk(CMD_BOTH, 32'hffff_ffff, 32'h0001_0000));
    pending_cmds.push_back(mk(CMD_REINIT, 32'h8000_0000, 32'h7fff_ffff));
    pending_cmds.push_back(mk(CMD_BOTH, 32'h0001_0000, 32'h8000_0000));
    pending_cmds.push_back(mk(CMD_REINIT, 0, 0));
    drain();

    // no measurement noise: covariance collapses and the floor on S kicks in
    load_regs(VEL_RST, LOAD_STEP_RST, CUR_RST, 32'h0100_0000, 64'h0, 64'h0, 31'd0);
    pending_cmds.push_back(mk(CMD_REINIT, 0, 0));
    repeat (4) pending_cmds.push_back(mk(CMD_UPDATE, 0, 32'h0002_0000));
    pending_cmds.push_back(mk(CMD_BOTH, 32'h0001_0000, 32'hfffe_0000));
    queue_random(80);
    drain();

    load_plausible();
    queue_random(250);
    drain();

    send_idle = 46;
    recv_idle = 25;
    // largest positive coefficients and noise: estimates and gains clip
    load_regs(64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff_7fff_ffff,
              32'h7fff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 31'h7fff_ffff);
    reg_write(REG_NONE, 64'h1234_5678_9abc_def0);
    pending_cmds.push_back(mk(CMD_REINIT, 0, 0));
    pending_cmds.push_back(mk(CMD_BOTH, 32'h7fff_ffff, 32'h8000_0000));
    pending_cmds.push_back(mk(CMD_PREDICT, 32'h7fff_ffff, 0));
    pending_cmds.push_back(mk(CMD_UPDATE, 0, 32'h7fff_ffff));
    queue_random(60);
    drain();

    load_plausible();
    queue_random(120);
    // sender holds off until everything outstanding has come back
    wait (pending_cmds.size() == 0 && !in_valid);
    hold_in = 1'b1;
    wait (expected_est.size() == 0);
    hold_in = 1'b0;
    queue_random(120);
    drain();

    send_idle = 0;
    recv_idle = 0;
    load_regs(64'h0, 64'h0, 64'h0, 32'h0, 64'h0, 64'h0, 31'd0);
    queue_random(100);
    drain();

    // most negative coefficients
    load_regs(64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
              32'h8000_0000, 64'h0000_0001_0000_0001, 64'h0, 31'd1);
    queue_random(60);
    drain();

    load_plausible();
    queue_random(530);
    drain();

    $display("%0d commands issued, %0d results checked, %0d with an update, %0d clipped",
             beats_in, beats_out, n_upd, n_clip);
    $display("register sets covered: reset, zero, extremes both ways, plausible motors");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
